@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/rpr_pkg.sv @@
// Types and constants shared by the reprojection residual modules.
package rpr_pkg;

    localparam int unsigned PROD_W  = 64;
    localparam int unsigned DEN_W   = 49;
    localparam int unsigned SUM_W   = 42;
    localparam int unsigned PROJ_W  = 41;
    localparam int unsigned RES_W   = 43;
    localparam int unsigned ROOT_W  = 21;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [PROJ_W-1:0] PROJ_MAX = {1'b1, {(PROJ_W-1){1'b0}}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    typedef enum logic [2:0] {
        REG_FOCAL   = 3'd0,
        REG_PRINC_X = 3'd1,
        REG_COS     = 3'd2,
        REG_SIN     = 3'd3,
        REG_CAM_X   = 3'd4,
        REG_CAM_Y   = 3'd5,
        REG_THRESH  = 3'd6,
        REG_NONE    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic        [15:0] focal_length;
        logic        [15:0] principal_x;
        logic signed [15:0] cos_heading;
        logic signed [15:0] sin_heading;
        logic signed [31:0] camera_x;
        logic signed [31:0] camera_y;
        logic        [15:0] inlier_threshold;
    } t_cfg;

    // One classified match handed from the front to the back.
    typedef struct packed {
        logic [PROD_W-1:0] num;
        logic [DEN_W-1:0]  abs_men;
        logic              neg;
        logic              zero_depth;
        logic [15:0]       image_column;
        logic              last_match;
    } t_match;

endpackage

@@ src/rpr_div.sv @@
// Restoring divider, one quotient bit per cycle.
module rpr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rpr_pkg::PROD_W-1:0] i_dividend,
    input  logic [rpr_pkg::DEN_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [rpr_pkg::PROD_W-1:0] o_quotient
);
    localparam int unsigned CNT_W = $clog2(rpr_pkg::PROD_W);

    logic                       r_busy;
    logic [CNT_W-1:0]           r_cnt;
    logic [rpr_pkg::DEN_W-1:0]  r_rem;
    logic [rpr_pkg::DEN_W-1:0]  r_den;
    logic [rpr_pkg::PROD_W-1:0] r_q;
    logic                       r_done;

    logic [rpr_pkg::DEN_W:0]    rem_sh;
    logic                       ge;
    logic [rpr_pkg::DEN_W:0]    rem_sub;

    assign rem_sh  = {r_rem, r_q[rpr_pkg::PROD_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_q    <= i_dividend;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[rpr_pkg::DEN_W-1:0] : rem_sh[rpr_pkg::DEN_W-1:0];
                r_q   <= {r_q[rpr_pkg::PROD_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(rpr_pkg::PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

@@ src/rpr_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
module rpr_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rpr_pkg::SUM_W-1:0]  i_value,
    output logic                       o_done,
    output logic [rpr_pkg::ROOT_W-1:0] o_root
);
    localparam int unsigned CNT_W = $clog2(rpr_pkg::ROOT_W);
    localparam int unsigned REM_W = rpr_pkg::ROOT_W + 3;

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [rpr_pkg::SUM_W-1:0]  r_x;
    logic [REM_W-1:0]           r_rem;
    logic [rpr_pkg::ROOT_W-1:0] r_root;

    logic [REM_W-1:0]           rem_t;
    logic [REM_W-1:0]           trial;
    logic                       ge;

    assign rem_t = {r_rem[REM_W-3:0], r_x[rpr_pkg::SUM_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_x    <= {r_x[rpr_pkg::SUM_W-3:0], 2'b00};
                r_rem  <= ge ? rem_t - trial : rem_t;
                r_root <= {r_root[rpr_pkg::ROOT_W-2:0], ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(rpr_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ src/rpr_front.sv @@
// Front part: takes a match, rotates it into the camera frame and scales it.
module rpr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rpr_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [15:0]          i_image_column,
    input  logic signed [31:0]   i_world_x,
    input  logic signed [31:0]   i_world_y,
    input  logic                 i_last_match,
    output logic                 o_push,
    output rpr_pkg::t_match      o_match,
    input  logic                 i_full
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_SUB, ST_M0, ST_M1, ST_M2, ST_M3, ST_FOC, ST_PUSH
    } t_state;

    t_state                    r_state;
    logic [15:0]               r_col;
    logic signed [31:0]        r_wx;
    logic signed [31:0]        r_wy;
    logic                      r_last;
    logic signed [32:0]        r_dx;
    logic signed [32:0]        r_dy;
    logic signed [49:0]        r_acc;
    logic signed [49:0]        r_den;
    logic [rpr_pkg::DEN_W-1:0] r_abs_men;
    logic                      r_neg;
    logic                      r_zero;
    logic [rpr_pkg::PROD_W-1:0] r_num;

    logic signed [15:0]        mul_a;
    logic signed [32:0]        mul_b;
    logic signed [48:0]        mul_p;
    logic signed [49:0]        men;
    logic [rpr_pkg::DEN_W-1:0] abs_den;
    logic [rpr_pkg::DEN_W+15:0] foc_p;

    // One shared signed multiplier walks the four rotation products.
    assign mul_a = (r_state == ST_M0 || r_state == ST_M2) ?
                   i_cfg.cos_heading : i_cfg.sin_heading;
    assign mul_b = (r_state == ST_M0 || r_state == ST_M3) ? r_dx : r_dy;
    assign mul_p = 49'(mul_a) * 49'(mul_b);
    assign men   = r_acc - 50'(mul_p);
    assign abs_den = r_den[49] ? rpr_pkg::DEN_W'(-r_den) : rpr_pkg::DEN_W'(r_den);
    assign foc_p   = abs_den * i_cfg.focal_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_col   <= i_image_column;
                        r_wx    <= i_world_x;
                        r_wy    <= i_world_y;
                        r_last  <= i_last_match;
                        r_state <= ST_SUB;
                    end
                end
                ST_SUB: begin
                    r_dx    <= 33'(r_wx) - 33'(i_cfg.camera_x);
                    r_dy    <= 33'(r_wy) - 33'(i_cfg.camera_y);
                    r_state <= ST_M0;
                end
                ST_M0: begin
                    r_acc   <= 50'(mul_p);
                    r_state <= ST_M1;
                end
                ST_M1: begin
                    r_den   <= r_acc + 50'(mul_p);
                    r_state <= ST_M2;
                end
                ST_M2: begin
                    r_acc   <= 50'(mul_p);
                    r_state <= ST_M3;
                end
                ST_M3: begin
                    r_abs_men <= men[49] ? rpr_pkg::DEN_W'(-men) : rpr_pkg::DEN_W'(men);
                    r_neg     <= r_den[49] ^ men[49];
                    r_zero    <= (men == '0);
                    r_state   <= ST_FOC;
                end
                ST_FOC: begin
                    r_num   <= rpr_pkg::PROD_W'(foc_p);
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!i_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_push  = (r_state == ST_PUSH) && !i_full;

    always_comb begin
        o_match.num          = r_num;
        o_match.abs_men      = r_abs_men;
        o_match.neg          = r_neg;
        o_match.zero_depth   = r_zero;
        o_match.image_column = r_col;
        o_match.last_match   = r_last;
    end
endmodule

@@ src/rpr_queue.sv @@
// Short register queue between the front and the back.
`include "assert_macros.svh"
module rpr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rpr_pkg::t_match i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output rpr_pkg::t_match o_data
);
    localparam int unsigned DEPTH = rpr_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rpr_pkg::t_match  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_data;
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    `ASSERT_CLK(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full, "queue push while full")
    `ASSERT_CLK(a_no_underflow, i_clk, i_rst_n, i_pop |-> o_valid, "queue pop while empty")
    `ASSERT_CLK(a_cnt_range, i_clk, i_rst_n, r_cnt <= CNT_W'(DEPTH), "queue count past depth")
endmodule

@@ src/rpr_back.sv @@
// Back part: divides, scores, accumulates and builds the pose result.
`include "assert_macros.svh"
module rpr_back #(
    parameter int unsigned MAX_MATCHES = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rpr_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    input  rpr_pkg::t_match i_match,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_rms_residual,
    output logic            o_rejected,
    output logic [10:0]     o_inlier_total,
    output logic [10:0]     o_match_total
);
    localparam int unsigned CW = $clog2(MAX_MATCHES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_MATCHES);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PDIV, ST_RES, ST_ACC, ST_CHK, ST_FDIV, ST_SQRT, ST_OUT
    } t_state;

    t_state                       r_state;
    rpr_pkg::t_match              r_item;
    logic [CW-1:0]                r_inl;
    logic [CW-1:0]                r_cnt;
    logic [rpr_pkg::SUM_W-1:0]    r_sum;
    logic [rpr_pkg::RES_W-1:0]    r_ares;
    logic [15:0]                  r_rms;
    logic                         r_rej;
    logic                         r_out_valid;
    logic [15:0]                  r_o_rms;
    logic                         r_o_rej;
    logic [10:0]                  r_o_inl;
    logic [10:0]                  r_o_cnt;

    logic                         div_start;
    logic [rpr_pkg::PROD_W-1:0]   div_a;
    logic [rpr_pkg::DEN_W-1:0]    div_b;
    logic                         div_done;
    logic [rpr_pkg::PROD_W-1:0]   div_q;
    logic                         sq_done;
    logic [rpr_pkg::ROOT_W-1:0]   sq_root;
    logic                         reject;
    logic [rpr_pkg::PROJ_W-1:0]   q_sat;
    logic signed [rpr_pkg::RES_W-1:0] proj;
    logic signed [rpr_pkg::RES_W-1:0] offs;
    logic signed [rpr_pkg::RES_W-1:0] res;
    logic [31:0]                  sq;
    logic [rpr_pkg::SUM_W:0]      sum_add;

    // Too few inliers: none at all, or inl < floor(cnt/3), which is the same as 3*(inl+1) <= cnt.
    assign reject = (r_inl == '0) ||
                    (((CW+2)'(r_inl) + 1'b1) * 3'd3 <= (CW+2)'(r_cnt));

    assign o_pop     = (r_state == ST_IDLE) && i_valid;
    assign div_start = (o_pop && !i_match.zero_depth) ||
                       (r_state == ST_CHK && r_item.last_match && !reject);
    assign div_a     = (r_state == ST_IDLE) ? i_match.num : rpr_pkg::PROD_W'(r_sum);
    assign div_b     = (r_state == ST_IDLE) ? i_match.abs_men : rpr_pkg::DEN_W'(r_inl);

    rpr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    rpr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_FDIV && div_done),
        .i_value (div_q[rpr_pkg::SUM_W-1:0]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign q_sat = (div_q > rpr_pkg::PROD_W'(rpr_pkg::PROJ_MAX)) ?
                   rpr_pkg::PROJ_MAX : div_q[rpr_pkg::PROJ_W-1:0];
    assign proj  = r_item.neg ? -$signed({2'b00, q_sat}) : $signed({2'b00, q_sat});
    assign offs  = $signed({27'd0, r_item.image_column}) - $signed({27'd0, i_cfg.principal_x});
    assign res   = proj - offs;
    assign sq    = r_ares[15:0] * r_ares[15:0];
    assign sum_add = {1'b0, r_sum} + (rpr_pkg::SUM_W+1)'(sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_inl       <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_item <= i_match;
                        if (r_cnt != CNT_MAX) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= i_match.zero_depth ? ST_CHK : ST_PDIV;
                    end
                end
                ST_PDIV: begin
                    if (div_done) begin
                        r_state <= ST_RES;
                    end
                end
                ST_RES: begin
                    r_ares  <= res[rpr_pkg::RES_W-1] ? rpr_pkg::RES_W'(-res)
                                                      : rpr_pkg::RES_W'(res);
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_ares < rpr_pkg::RES_W'(i_cfg.inlier_threshold)) begin
                        if (r_inl != CNT_MAX) begin
                            r_inl <= r_inl + 1'b1;
                        end
                        r_sum <= sum_add[rpr_pkg::SUM_W] ? rpr_pkg::SUM_MAX
                                                         : sum_add[rpr_pkg::SUM_W-1:0];
                    end
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (!r_item.last_match) begin
                        r_state <= ST_IDLE;
                    end else if (reject) begin
                        r_rej   <= 1'b1;
                        r_rms   <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_rej   <= 1'b0;
                        r_state <= ST_FDIV;
                    end
                end
                ST_FDIV: begin
                    if (div_done) begin
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sq_done) begin
                        r_rms   <= (sq_root > rpr_pkg::ROOT_W'(16'hFFFF)) ? 16'hFFFF
                                                                          : sq_root[15:0];
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_o_rms     <= r_rms;
                        r_o_rej     <= r_rej;
                        r_o_inl     <= 11'(r_inl);
                        r_o_cnt     <= 11'(r_cnt);
                        r_inl       <= '0;
                        r_cnt       <= '0;
                        r_sum       <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_rms_residual = r_o_rms;
    assign o_rejected     = r_o_rej;
    assign o_inlier_total = r_o_inl;
    assign o_match_total  = r_o_cnt;

    `ASSERT_CLK(a_inl_le_cnt, i_clk, i_rst_n, r_inl <= r_cnt, "inlier count above match count")
    `ASSERT_CLK(a_cnt_cap, i_clk, i_rst_n, r_cnt <= CNT_MAX, "match count past its limit")
    `ASSERT_CLK(a_final_div_nonzero, i_clk, i_rst_n,
        (div_start && r_state == ST_CHK) |-> (r_inl != '0), "final division by zero inliers")
    `ASSERT_CLK(a_clear_after_result, i_clk, i_rst_n,
        (r_state == ST_OUT && !r_out_valid) |=> (r_cnt == '0 && r_sum == '0),
        "state not cleared after result")
endmodule

@@ src/pose_reprojection_residual.sv @@
// Top level: register port, front, queue and back of the pose residual scorer.
//
//  Channel      Direction  Handshake            Item
//  s_axis       in         tvalid/tready        one match (tlast ends the pose)
//  m_axis       out        tvalid/tready        one pose score
//  APB          in/out     psel/penable/pready  register write or read
//
// The front takes a new match only once the last one is pushed to the queue;
// the back runs each match with nonzero depth through the 64-step divider it
// shares with the final mean, and skips the divider for a zero-depth match.
// A last match that is not rejected adds the mean division and square root.
// Reset is synchronous and active low; state, count and config registers return to their defaults.
// The two-entry queue and the output register let either side stall alone.
module pose_reprojection_residual #(
    parameter int unsigned MAX_MATCHES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // image_column[15:0], world_x[47:16], world_y[79:48]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // rms_residual[15:0], inlier_total[26:16],
                                       // match_total[37:27], zero[39:38]
    output logic        m_axis_tuser,  // rejected
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    rpr_pkg::t_cfg    r_cfg;
    rpr_pkg::t_reg_idx reg_idx;
    rpr_pkg::t_match  fr_match;
    rpr_pkg::t_match  q_match;
    logic             fr_push;
    logic             q_full;
    logic             q_valid;
    logic             bk_pop;
    logic [15:0]      rms;
    logic [10:0]      inl_total;
    logic [10:0]      match_total;

    assign pready  = 1'b1;
    assign reg_idx = rpr_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_length     <= 16'd16000;
            r_cfg.principal_x      <= 16'd5120;
            r_cfg.cos_heading      <= 16'sd16384;
            r_cfg.sin_heading      <= '0;
            r_cfg.camera_x         <= '0;
            r_cfg.camera_y         <= '0;
            r_cfg.inlier_threshold <= 16'd800;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                rpr_pkg::REG_FOCAL:   r_cfg.focal_length     <= pwdata[15:0];
                rpr_pkg::REG_PRINC_X: r_cfg.principal_x      <= pwdata[15:0];
                rpr_pkg::REG_COS:     r_cfg.cos_heading      <= pwdata[15:0];
                rpr_pkg::REG_SIN:     r_cfg.sin_heading      <= pwdata[15:0];
                rpr_pkg::REG_CAM_X:   r_cfg.camera_x         <= pwdata;
                rpr_pkg::REG_CAM_Y:   r_cfg.camera_y         <= pwdata;
                rpr_pkg::REG_THRESH:  r_cfg.inlier_threshold <= pwdata[15:0];
                rpr_pkg::REG_NONE:    ;
                default:              ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rpr_pkg::REG_FOCAL:   prdata = {16'd0, r_cfg.focal_length};
            rpr_pkg::REG_PRINC_X: prdata = {16'd0, r_cfg.principal_x};
            rpr_pkg::REG_COS:     prdata = 32'(r_cfg.cos_heading);
            rpr_pkg::REG_SIN:     prdata = 32'(r_cfg.sin_heading);
            rpr_pkg::REG_CAM_X:   prdata = r_cfg.camera_x;
            rpr_pkg::REG_CAM_Y:   prdata = r_cfg.camera_y;
            rpr_pkg::REG_THRESH:  prdata = {16'd0, r_cfg.inlier_threshold};
            rpr_pkg::REG_NONE:    prdata = '0;
            default:              prdata = '0;
        endcase
    end

    rpr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_image_column (s_axis_tdata[15:0]),
        .i_world_x      (s_axis_tdata[47:16]),
        .i_world_y      (s_axis_tdata[79:48]),
        .i_last_match   (s_axis_tlast),
        .o_push         (fr_push),
        .o_match        (fr_match),
        .i_full         (q_full)
    );

    rpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  (fr_match),
        .o_full  (q_full),
        .i_pop   (bk_pop),
        .o_valid (q_valid),
        .o_data  (q_match)
    );

    rpr_back #(
        .MAX_MATCHES (MAX_MATCHES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (q_valid),
        .i_match        (q_match),
        .o_pop          (bk_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_rms_residual (rms),
        .o_rejected     (m_axis_tuser),
        .o_inlier_total (inl_total),
        .o_match_total  (match_total)
    );

    assign m_axis_tdata = {2'b00, match_total, inl_total, rms};
endmodule
